// ===== rtl/core/irps_pkg.sv =====
// Shared types, constants and control store for the ratio PD steering block.
`default_nettype none
package irps_pkg;

    localparam int PC_W     = 4;
    localparam int CHAN_W   = 8;
    localparam int GAIN_W   = 8;
    localparam int THR_W    = 10;
    localparam int ERR_W    = 8;
    localparam int TGT_W    = 32;
    localparam int WSUM_W   = 10;
    localparam int DEN_W    = 11;
    localparam int NUM_W    = 17;
    localparam int QUO_W    = 7;
    localparam int CNT_W    = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [6:0] RATIO_SCALE = 7'd100;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_THR   = 2'd2;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 8'd4;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 8'd4;
    localparam logic [THR_W-1:0]  STOP_THR_RST   = 10'd30;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_SUMS,
        OP_PREP,
        OP_DIV,
        OP_SIGN,
        OP_MUL,
        OP_ACC,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        J_NEXT,
        J_ALWAYS,
        J_NOIN,
        J_DEN0,
        J_MORE,
        J_OUTBUSY
    } jmp_t;

    typedef struct packed {
        op_t             op;
        jmp_t            jmp;
        logic [PC_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic den_zero;
        logic div_more;
        logic out_busy;
    } dp_status_t;

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        unique case (pc)
            4'd0:    w = '{op: OP_NOP,  jmp: J_NOIN,    target: 4'd0};
            4'd1:    w = '{op: OP_SUMS, jmp: J_NEXT,    target: 4'd0};
            4'd2:    w = '{op: OP_PREP, jmp: J_NEXT,    target: 4'd0};
            4'd3:    w = '{op: OP_NOP,  jmp: J_DEN0,    target: 4'd5};
            4'd4:    w = '{op: OP_DIV,  jmp: J_MORE,    target: 4'd4};
            4'd5:    w = '{op: OP_SIGN, jmp: J_NEXT,    target: 4'd0};
            4'd6:    w = '{op: OP_MUL,  jmp: J_NEXT,    target: 4'd0};
            4'd7:    w = '{op: OP_ACC,  jmp: J_NEXT,    target: 4'd0};
            4'd8:    w = '{op: OP_NOP,  jmp: J_OUTBUSY, target: 4'd8};
            4'd9:    w = '{op: OP_EMIT, jmp: J_ALWAYS,  target: 4'd0};
            default: w = '{op: OP_NOP,  jmp: J_ALWAYS,  target: 4'd0};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/irps_seq.sv =====
// Microcode sequencer: step counter, control store lookup and jump logic.
`default_nettype none
module irps_seq
    import irps_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire dp_status_t status,
    output ucode_t          ctrl
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic [PC_W-1:0] pc_inc;
    logic            in_fire;

    assign ctrl     = ucode_rom(pc_reg);
    assign in_ready = (pc_reg == '0);
    assign in_fire  = in_valid && in_ready;
    assign pc_inc   = pc_reg + 1'b1;

    always_comb
    begin
        unique case (ctrl.jmp)
            J_NEXT:    pc_next = pc_inc;
            J_ALWAYS:  pc_next = ctrl.target;
            J_NOIN:    pc_next = in_fire ? pc_inc : ctrl.target;
            J_DEN0:    pc_next = status.den_zero ? ctrl.target : pc_inc;
            J_MORE:    pc_next = status.div_more ? ctrl.target : pc_inc;
            J_OUTBUSY: pc_next = status.out_busy ? ctrl.target : pc_inc;
            default:   pc_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= '0;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/irps_dpath.sv =====
// Datapath: weighted sums, restoring divider, PD update, output register.
`default_nettype none
module irps_dpath
    import irps_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_fire,
    input  wire logic [4*CHAN_W-1:0]  in_data,
    input  wire op_t                  op,
    input  wire logic [GAIN_W-1:0]    prop_gain,
    input  wire logic [GAIN_W-1:0]    deriv_gain,
    input  wire logic [THR_W-1:0]     stop_threshold,
    output dp_status_t                status,
    output logic                      out_valid,
    input  wire logic                 out_taken,
    output logic signed [ERR_W-1:0]   ratio_error,
    output logic signed [TGT_W-1:0]   heading_target,
    output logic                      stop_flag
);

    logic [CHAN_W-1:0]        c1_reg, c2_reg, c3_reg, c4_reg;
    logic [WSUM_W-1:0]        left_reg, right_reg;
    logic [NUM_W-1:0]         rem_reg;
    logic [DEN_W-1:0]         den_reg;
    logic                     neg_reg;
    logic [QUO_W-1:0]         quo_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic signed [ERR_W-1:0]  err_reg;
    logic signed [ERR_W-1:0]  prev_err_reg;
    logic signed [16:0]       pterm_reg;
    logic signed [17:0]       dterm_reg;
    logic signed [TGT_W-1:0]  accum_reg;
    logic                     stop_reg;
    logic                     out_valid_reg;
    logic signed [ERR_W-1:0]  out_err_reg;
    logic signed [TGT_W-1:0]  out_tgt_reg;
    logic                     out_stop_reg;

    logic [WSUM_W-1:0]        left_sum, right_sum, raw_sum;
    logic [WSUM_W-1:0]        mag;
    logic [NUM_W-1:0]         num;
    logic [NUM_W:0]           trial;
    logic signed [ERR_W-1:0]  err_val;
    logic signed [ERR_W:0]    err_diff;
    logic signed [16:0]       pterm;
    logic signed [17:0]       dterm;
    logic signed [18:0]       delta;
    logic signed [TGT_W:0]    acc_sum;
    logic signed [TGT_W-1:0]  acc_sat;

    always_comb
    begin
        left_sum  = {2'b0, c1_reg} + {1'b0, c2_reg, 1'b0} + {2'b0, c2_reg};
        right_sum = {2'b0, c4_reg} + {1'b0, c3_reg, 1'b0} + {2'b0, c3_reg};
        raw_sum   = {2'b0, c1_reg} + {2'b0, c2_reg} + {2'b0, c3_reg} + {2'b0, c4_reg};
        mag       = (left_reg >= right_reg) ? (left_reg - right_reg) : (right_reg - left_reg);
        num       = NUM_W'(mag) * NUM_W'(RATIO_SCALE);
        trial     = ({{(NUM_W+1-DEN_W){1'b0}}, den_reg} << cnt_reg);
        err_val   = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
        err_diff  = {err_reg[ERR_W-1], err_reg} - {prev_err_reg[ERR_W-1], prev_err_reg};
        pterm     = $signed({1'b0, prop_gain}) * err_reg;
        dterm     = $signed({1'b0, deriv_gain}) * err_diff;
        delta     = {{2{pterm_reg[16]}}, pterm_reg} + {dterm_reg[17], dterm_reg};
        acc_sum   = {accum_reg[TGT_W-1], accum_reg} + {{(TGT_W-18){delta[18]}}, delta};
        if (acc_sum[TGT_W] != acc_sum[TGT_W-1])
        begin
            acc_sat = acc_sum[TGT_W] ? {1'b1, {(TGT_W-1){1'b0}}} : {1'b0, {(TGT_W-1){1'b1}}};
        end
        else
        begin
            acc_sat = acc_sum[TGT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            c1_reg <= in_data[CHAN_W-1:0];
            c2_reg <= in_data[2*CHAN_W-1:CHAN_W];
            c3_reg <= in_data[3*CHAN_W-1:2*CHAN_W];
            c4_reg <= in_data[4*CHAN_W-1:3*CHAN_W];
        end
        unique case (op)
            OP_SUMS:
            begin
                left_reg  <= left_sum;
                right_reg <= right_sum;
            end
            OP_PREP:
            begin
                rem_reg <= num;
                den_reg <= DEN_W'(left_reg) + DEN_W'(right_reg);
                neg_reg <= (left_reg < right_reg);
                quo_reg <= '0;
                cnt_reg <= CNT_W'(QUO_W - 1);
            end
            OP_DIV:
            begin
                if ({1'b0, rem_reg} >= trial)
                begin
                    rem_reg          <= NUM_W'({1'b0, rem_reg} - trial);
                    quo_reg[cnt_reg] <= 1'b1;
                end
                cnt_reg <= cnt_reg - 1'b1;
            end
            OP_SIGN:
            begin
                err_reg <= err_val;
            end
            OP_MUL:
            begin
                pterm_reg <= pterm;
                dterm_reg <= dterm;
            end
            OP_NOP, OP_ACC, OP_EMIT:
            begin
            end
            default:
            begin
            end
        endcase
        if (op == OP_EMIT)
        begin
            out_err_reg  <= err_reg;
            out_tgt_reg  <= accum_reg;
            out_stop_reg <= stop_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg  <= '0;
            accum_reg     <= '0;
            stop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (op == OP_SUMS && raw_sum <= stop_threshold)
            begin
                stop_reg <= 1'b1;
            end
            if (op == OP_ACC)
            begin
                accum_reg    <= acc_sat;
                prev_err_reg <= err_reg;
            end
            if (op == OP_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_taken)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.den_zero = (den_reg == '0);
    assign status.div_more = (cnt_reg != '0);
    assign status.out_busy = out_valid_reg;

    assign out_valid      = out_valid_reg;
    assign ratio_error    = out_err_reg;
    assign heading_target = out_tgt_reg;
    assign stop_flag      = out_stop_reg;

endmodule
`default_nettype wire

// ===== rtl/core/inductor_ratio_pd_steering.sv =====
// Each request runs weighted sums, divider set-up, the 7-step divider (skipped for a zero
// sum), sign, PD multiply, accumulate and emit; no new request is taken before emit.
// A new request is taken while the previous result waits in the output register.
// Reset (rst_n low, asynchronous): gains 4, threshold 30, target, last error and
// stop flag cleared, no result pending.
`default_nettype none
module inductor_ratio_pd_steering
    import irps_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // chan_one[7:0], chan_two[15:8], chan_three[23:16], chan_four[31:24]
    input  wire logic [31:0]          s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // ratio_error[7:0], heading_target[39:8], stop_flag[40], zero[47:41]
    output logic [47:0]               m_axis_tdata,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [THR_W-1:0]     cfg_data
);

    logic [GAIN_W-1:0]       prop_gain_reg;
    logic [GAIN_W-1:0]       deriv_gain_reg;
    logic [THR_W-1:0]        stop_thr_reg;
    ucode_t                  ctrl;
    dp_status_t              status;
    logic                    in_fire;
    logic signed [ERR_W-1:0] ratio_error;
    logic signed [TGT_W-1:0] heading_target;
    logic                    stop_flag;

    assign cfg_ready = 1'b1;
    assign in_fire   = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg  <= PROP_GAIN_RST;
            deriv_gain_reg <= DERIV_GAIN_RST;
            stop_thr_reg   <= STOP_THR_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PROP_GAIN:  prop_gain_reg  <= cfg_data[GAIN_W-1:0];
                REG_DERIV_GAIN: deriv_gain_reg <= cfg_data[GAIN_W-1:0];
                REG_STOP_THR:   stop_thr_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    irps_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .ctrl     (ctrl)
    );

    irps_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_fire        (in_fire),
        .in_data        (s_axis_tdata),
        .op             (ctrl.op),
        .prop_gain      (prop_gain_reg),
        .deriv_gain     (deriv_gain_reg),
        .stop_threshold (stop_thr_reg),
        .status         (status),
        .out_valid      (m_axis_tvalid),
        .out_taken      (m_axis_tready),
        .ratio_error    (ratio_error),
        .heading_target (heading_target),
        .stop_flag      (stop_flag)
    );

    assign m_axis_tdata = {7'b0, stop_flag, heading_target, ratio_error};

endmodule
`default_nettype wire
